// File: rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types, codes and constants of the bitmap run-length decoder.
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W  = 13;   // width / height / column
    localparam int POS_W  = 25;   // linear position, holds width*height itself
    localparam int ADDR_W = 24;   // pixel address as it leaves the block
    localparam int BYTE_W = 8;
    localparam int PROD_W = BYTE_W + DIM_W;
    localparam int CNT_W  = 3;
    localparam int OUT_W  = 64;

    localparam logic [DIM_W-1:0] MAX_WIDTH_D  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_D = DIM_W'(MAX_HEIGHT);

    localparam logic [BYTE_W-1:0] NIB_LO_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] NIB_HI_MASK = 8'hF0;

    // escape codes following a zero count byte
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_EOI   = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'h02;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_ESC,
        PH_DX,
        PH_DY,
        PH_ABS,
        PH_PAD
    } phase_t;

    typedef enum logic [1:0] {
        CFG_FOUR_BIT = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic accept;     // latch the incoming byte
        logic step;       // perform one decode step, may load a result
        logic cfg_write;  // configuration beat
        logic restart;    // configuration beat to a known register
    } brd_cmd_t;

    typedef struct packed {
        logic finished;   // decoding over, bytes are dropped
        logic more;       // current byte still has pixel groups to give
        logic slot_free;  // output register can take a result this cycle
    } brd_status_t;

    // zero reads as one, anything above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > lim)
            r = lim;
        return r;
    endfunction

endpackage

// File: rtl/brd_ctrl.sv
// ----------------------------------------------------------------------------
// brd_ctrl
// Sequencer: takes one byte at a time and steps the datapath until the
// byte's results are all in the output register.
// ----------------------------------------------------------------------------
module brd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_addr,
    output logic                  cfg_ready,
    input  brd_pkg::brd_status_t  status,
    output brd_pkg::brd_cmd_t     cmd
);

    brd_pkg::ctrl_state_t state_reg;
    brd_pkg::ctrl_state_t state_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brd_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        cmd.cfg_write = cfg_valid;
        cmd.restart   = cfg_valid && (cfg_addr == brd_pkg::CFG_FOUR_BIT ||
                                      cfg_addr == brd_pkg::CFG_WIDTH ||
                                      cfg_addr == brd_pkg::CFG_HEIGHT);
        case (state_reg)
            brd_pkg::CS_IDLE:
            begin
                // a configuration beat has priority over data
                in_ready = !cfg_valid;
                if (in_valid && !cfg_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.finished)
                        state_next = brd_pkg::CS_EXEC;
                end
            end
            brd_pkg::CS_EXEC:
            begin
                if (status.slot_free)
                begin
                    cmd.step = 1'b1;
                    if (!status.more)
                        state_next = brd_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = brd_pkg::CS_IDLE;
            end
        endcase
        if (cmd.restart)
            state_next = brd_pkg::CS_IDLE;
    end

endmodule

// File: rtl/brd_datapath.sv
// ----------------------------------------------------------------------------
// brd_datapath
// Decoder state, configuration registers, pixel group builder and the
// output register.
// ----------------------------------------------------------------------------
module brd_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  brd_pkg::brd_cmd_t              cmd,
    output brd_pkg::brd_status_t           status,
    input  logic [1:0]                     cfg_addr,
    input  logic [brd_pkg::DIM_W-1:0]      cfg_data,
    input  logic [brd_pkg::BYTE_W-1:0]     in_data,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [brd_pkg::OUT_W-1:0]      out_data,
    output logic                           out_last,
    output logic                           out_user
);

    localparam int DW = brd_pkg::DIM_W;
    localparam int PW = brd_pkg::POS_W;
    localparam int BW = brd_pkg::BYTE_W;
    localparam int CW = brd_pkg::CNT_W;

    // configuration
    logic          four_reg;
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [PW-1:0] total_reg;

    // latched byte
    logic [BW-1:0]              byte_reg;
    logic                       last_reg;
    logic [brd_pkg::PROD_W-1:0] prod_reg;

    // decode state
    brd_pkg::phase_t phase_reg, phase_next;
    logic [BW-1:0]   run_len_reg, run_len_next;
    logic [BW-1:0]   run_idx_reg, run_idx_next;
    logic [BW-1:0]   k_reg, k_next;
    logic [PW-1:0]   wp_reg, wp_next;
    logic [DW-1:0]   col_reg, col_next;
    logic [BW-1:0]   dcol_reg, dcol_next;
    logic            pad_reg, pad_next;
    logic            fin_reg, fin_next;

    // output register
    logic                        out_valid_reg;
    logic [brd_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [BW-1:0]               out_pa_reg, out_pb_reg, out_pc_reg, out_pd_reg;
    logic [CW-1:0]               out_cnt_reg;
    logic                        out_last_reg;
    logic                        out_done_reg;

    logic [DW-1:0]     eff_w, eff_h;
    logic [2*DW-1:0]   area;
    logic [brd_pkg::PROD_W-1:0] prod_in;
    logic              slot_free;

    logic [DW-1:0]     rem_col;
    logic [PW-1:0]     rem_tot;
    logic [BW-1:0]     rem_run;
    logic [CW-1:0]     col_cap, tot_cap, run_cap, req_cap, n_a, n;
    logic [BW:0]       idx_inc, idx_new, b_inc;
    logic              abs_second;
    logic [PW-1:0]     wp_px, wp_eol, pos_dy;
    logic [DW-1:0]     col_px, step_dy;
    logic [BW-1:0]     k_px;
    logic              fin_cond, run_end, emit, load;
    logic [BW-1:0]     pix_hi, pix_lo, pix_a, pix_b;

    assign eff_w   = brd_pkg::clamp_dim(width_reg, brd_pkg::MAX_WIDTH_D);
    assign eff_h   = brd_pkg::clamp_dim(height_reg, brd_pkg::MAX_HEIGHT_D);
    assign area    = eff_w * eff_h;
    assign prod_in = {{DW{1'b0}}, in_data} * {{BW{1'b0}}, eff_w};

    assign slot_free = !out_valid_reg || out_ready;

    assign pix_hi = (byte_reg & brd_pkg::NIB_HI_MASK) >> 4;
    assign pix_lo = byte_reg & brd_pkg::NIB_LO_MASK;
    assign pix_a  = four_reg ? pix_hi : byte_reg;
    assign pix_b  = four_reg ? pix_lo : byte_reg;

    // pixel group size: limited by the run, the row end and the pixel total
    always_comb
    begin
        rem_col = eff_w - col_reg;
        rem_tot = total_reg - wp_reg;
        rem_run = run_len_reg - k_reg;
        col_cap = (rem_col >= DW'(4)) ? CW'(4) : rem_col[CW-1:0];
        tot_cap = (rem_tot >= PW'(4)) ? CW'(4) : rem_tot[CW-1:0];
        run_cap = (rem_run >= BW'(4)) ? CW'(4) : rem_run[CW-1:0];
        idx_inc = {1'b0, run_idx_reg} + (BW+1)'(1);
        abs_second = four_reg && (idx_inc < {1'b0, run_len_reg});
        case (phase_reg)
            brd_pkg::PH_VALUE: req_cap = run_cap;
            brd_pkg::PH_ABS:   req_cap = abs_second ? CW'(2) : CW'(1);
            default:           req_cap = '0;
        endcase
        n_a = (req_cap < col_cap) ? req_cap : col_cap;
        n   = (n_a < tot_cap) ? n_a : tot_cap;
    end

    always_comb
    begin
        wp_px   = wp_reg + PW'(n);
        col_px  = col_reg + DW'(n);
        k_px    = k_reg + BW'(n);
        wp_eol  = wp_reg + PW'(rem_col);
        step_dy = ({{(DW-BW){1'b0}}, dcol_reg} > rem_col) ? rem_col
                                                          : {{(DW-BW){1'b0}}, dcol_reg};
        pos_dy  = wp_reg + PW'(step_dy) + PW'(prod_reg);
        idx_new = abs_second ? idx_inc + (BW+1)'(1) : idx_inc;
        b_inc   = {1'b0, byte_reg} + (BW+1)'(1);

        phase_next   = phase_reg;
        run_len_next = run_len_reg;
        run_idx_next = run_idx_reg;
        k_next       = k_reg;
        wp_next      = wp_reg;
        col_next     = col_reg;
        dcol_next    = dcol_reg;
        pad_next     = pad_reg;
        fin_cond     = 1'b0;
        run_end      = 1'b1;

        case (phase_reg)
            brd_pkg::PH_VALUE:
            begin
                k_next   = k_px;
                wp_next  = wp_px;
                col_next = col_px;
                fin_cond = wp_px >= total_reg;
                run_end  = (k_px >= run_len_reg) || (col_px >= eff_w) || fin_cond;
                phase_next = run_end ? brd_pkg::PH_COUNT : brd_pkg::PH_VALUE;
            end
            brd_pkg::PH_ABS:
            begin
                wp_next      = wp_px;
                col_next     = col_px;
                fin_cond     = wp_px >= total_reg;
                run_idx_next = idx_new[BW-1:0];
                if (idx_new >= {1'b0, run_len_reg})
                    phase_next = pad_reg ? brd_pkg::PH_PAD : brd_pkg::PH_COUNT;
            end
            brd_pkg::PH_ESC:
            begin
                case (byte_reg)
                    brd_pkg::ESC_EOL:
                    begin
                        wp_next    = wp_eol;
                        col_next   = '0;
                        fin_cond   = wp_eol >= total_reg;
                        phase_next = brd_pkg::PH_COUNT;
                    end
                    brd_pkg::ESC_EOI:
                    begin
                        fin_cond   = 1'b1;
                        phase_next = brd_pkg::PH_COUNT;
                    end
                    brd_pkg::ESC_DELTA:
                    begin
                        phase_next = brd_pkg::PH_DX;
                    end
                    default:
                    begin
                        // absolute run; padding depends on bytes, not pixels
                        run_len_next = byte_reg;
                        run_idx_next = '0;
                        pad_next     = four_reg ? b_inc[1] : byte_reg[0];
                        phase_next   = brd_pkg::PH_ABS;
                    end
                endcase
            end
            brd_pkg::PH_DX:
            begin
                dcol_next  = byte_reg;
                phase_next = brd_pkg::PH_DY;
            end
            brd_pkg::PH_DY:
            begin
                col_next = col_reg + step_dy;
                if (pos_dy >= total_reg)
                begin
                    wp_next  = total_reg;
                    fin_cond = 1'b1;
                end
                else
                begin
                    wp_next = pos_dy;
                end
                phase_next = brd_pkg::PH_COUNT;
            end
            brd_pkg::PH_PAD:
            begin
                pad_next   = 1'b0;
                phase_next = brd_pkg::PH_COUNT;
            end
            brd_pkg::PH_COUNT:
            begin
                if (byte_reg != '0)
                begin
                    run_len_next = byte_reg;
                    k_next       = '0;
                    phase_next   = brd_pkg::PH_VALUE;
                end
                else
                begin
                    phase_next = brd_pkg::PH_ESC;
                end
            end
            default:
            begin
                phase_next = brd_pkg::PH_COUNT;
            end
        endcase

        fin_next = fin_cond || (run_end && last_reg);
        emit     = (n != '0) || (run_end && fin_next);
    end

    assign load = cmd.step && emit;

    assign status.finished  = fin_reg;
    assign status.more      = !run_end;
    assign status.slot_free = slot_free;

    // configuration and derived pixel total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_reg   <= 1'b0;
            width_reg  <= DW'(1);
            height_reg <= DW'(1);
            total_reg  <= PW'(1);
        end
        else
        begin
            total_reg <= area[PW-1:0];
            if (cmd.cfg_write)
            begin
                case (cfg_addr)
                    brd_pkg::CFG_FOUR_BIT: four_reg   <= cfg_data[0];
                    brd_pkg::CFG_WIDTH:    width_reg  <= cfg_data;
                    brd_pkg::CFG_HEIGHT:   height_reg <= cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    // byte latch, with the row offset of a delta precomputed
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_data;
            last_reg <= in_last;
            prod_reg <= prod_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= brd_pkg::PH_COUNT;
            run_len_reg <= '0;
            run_idx_reg <= '0;
            k_reg       <= '0;
            wp_reg      <= '0;
            col_reg     <= '0;
            dcol_reg    <= '0;
            pad_reg     <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else if (cmd.restart)
        begin
            phase_reg   <= brd_pkg::PH_COUNT;
            run_len_reg <= '0;
            run_idx_reg <= '0;
            k_reg       <= '0;
            wp_reg      <= '0;
            col_reg     <= '0;
            dcol_reg    <= '0;
            pad_reg     <= 1'b0;
            fin_reg     <= 1'b0;
        end
        else if (cmd.step)
        begin
            phase_reg   <= phase_next;
            run_len_reg <= run_len_next;
            run_idx_reg <= run_idx_next;
            k_reg       <= k_next;
            wp_reg      <= wp_next;
            col_reg     <= col_next;
            dcol_reg    <= dcol_next;
            pad_reg     <= pad_next;
            fin_reg     <= fin_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            // an empty result carries the position after the byte
            out_addr_reg <= (n != '0) ? wp_reg[brd_pkg::ADDR_W-1:0]
                                      : wp_next[brd_pkg::ADDR_W-1:0];
            out_pa_reg   <= (n >= CW'(1)) ? pix_a : '0;
            out_pb_reg   <= (n >= CW'(2)) ? pix_b : '0;
            out_pc_reg   <= (n >= CW'(3)) ? pix_a : '0;
            out_pd_reg   <= (n >= CW'(4)) ? pix_b : '0;
            out_cnt_reg  <= n;
            out_last_reg <= run_end;
            out_done_reg <= run_end && fin_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_done_reg;
    assign out_data  = {{(brd_pkg::OUT_W - brd_pkg::ADDR_W - 4*BW - CW){1'b0}},
                        out_cnt_reg, out_pd_reg, out_pc_reg, out_pb_reg, out_pa_reg,
                        out_addr_reg};

`ifndef SYNTH
    a_no_step_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !fin_reg)
        else $error("decode step issued after decoding finished");

    a_position_inside_image: assert property (@(posedge clk) disable iff (!rst_n)
        !fin_reg |-> (wp_reg < total_reg))
        else $error("write position reached the pixel total without finishing");

    a_column_inside_row: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.restart && !$past(cmd.cfg_write) |-> (col_reg <= eff_w))
        else $error("column beyond row width");

    a_load_only_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> slot_free)
        else $error("result overwrote a beat still waiting");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_cnt_reg <= CW'(4)))
        else $error("pixel count above four");
`endif

endmodule

// File: rtl/bitmap_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// bitmap_rle_decoder_core
// Run-length decoder for 8-bit and 4-bit compressed bitmap streams: one
// compressed byte in, groups of up to four pixels with their position out.
//
//   channel   dir  handshake                  content
//   s_axis    in   s_axis_tvalid/tready       compressed byte, tlast = last byte
//   m_axis    out  m_axis_tvalid/tready       pixel group, tlast = last of byte,
//                                             tuser = image done
//   cfg       in   cfg_valid/cfg_ready        register index, write data
//
// A byte is taken in the idle state and decoded in the execute state that
// follows; an encoded run needs one decode step per group of up to four
// pixels, and the sequencer steps the shared group builder once per result.
// A full output register with m_axis_tready low holds the sequencer.
// Reset clears all decode state; a configuration beat to a known register restarts decoding.
// ----------------------------------------------------------------------------
module bitmap_rle_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,   // last_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [23:0] pixel_address, [31:24] pixel_a, [39:32] pixel_b,
    // [47:40] pixel_c, [55:48] pixel_d, [58:56] pixel_count, [63:59] zero
    output logic [brd_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tlast,   // run_last
    output logic                        m_axis_tuser,   // [0] image_done
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_addr,
    input  logic [brd_pkg::DIM_W-1:0]   cfg_data
);

    brd_pkg::brd_cmd_t    cmd;
    brd_pkg::brd_status_t status;

    brd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    brd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule

// File: tb/bitmap_rle_decoder_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_rle_decoder_core_test
// Self-checking bench for the run-length bitmap decoder. A short table of
// directed bytes and register writes is followed by random well-formed runs,
// escapes, deltas and absolute runs with some noise and early stream ends.
// Every pixel group that leaves the block is compared with a behavioural
// decoder kept inside the bench, or with a fixed group for the directed rows
// that end the image, under several idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module bitmap_rle_decoder_core_test;

    localparam int HOLD_CYCLES  = 300;  // long output hold-off
    localparam int DRAIN_CYCLES = 8;    // a byte may still be in flight with no group due
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 5;

    localparam logic [7:0] RUN_ESCAPE = 8'h00;   // zero count byte opens an escape
    localparam logic [1:0] CFG_SPARE  = 2'd3;    // unmapped register index

    typedef struct packed {
        logic [23:0] addr;
        logic [7:0]  pa;
        logic [7:0]  pb;
        logic [7:0]  pc;
        logic [7:0]  pd;
        logic [2:0]  cnt;
        logic        run_last;
        logic        done;
    } pix_grp_t;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [12:0] value;
        logic        last;
        logic        typed;
        pix_grp_t    want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [12:0] cfg_data = '0;

    logic                        s_axis_tready;
    logic                        m_axis_tvalid;
    logic [brd_pkg::OUT_W-1:0]   m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        m_axis_tuser;
    logic                        cfg_ready;

    // decoder state as the bench sees it
    bit              nib_mode;
    logic [12:0]     width_reg;
    logic [12:0]     height_reg;
    brd_pkg::phase_t dec_phase;
    logic [7:0]      run_len;
    logic [7:0]      run_idx;
    logic [7:0]      dcol;
    int unsigned     wpos;
    int unsigned     col;
    bit              pad_pend;
    bit              img_over;

    logic [7:0]  acc_px [4];
    int unsigned acc_n;
    int unsigned acc_addr;

    pix_grp_t    byte_groups [$];
    pix_grp_t    groups_due [$];
    int          mismatches = 0;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_wanted = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    plan_row_t   plan [$];

    bitmap_rle_decoder_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // behavioural decoder
    // ------------------------------------------------------------------
    function automatic int unsigned used_dim(logic [12:0] v, int unsigned lim);
        int unsigned r;
        r = v;
        if (r == 0)
            r = 1;
        else if (r > lim)
            r = lim;
        return r;
    endfunction

    function automatic int unsigned used_width();
        return used_dim(width_reg, brd_pkg::MAX_WIDTH);
    endfunction

    function automatic int unsigned pixel_total();
        return used_width() * used_dim(height_reg, brd_pkg::MAX_HEIGHT);
    endfunction

    function automatic void restart_decode();
        dec_phase = brd_pkg::PH_COUNT;
        run_len   = '0;
        run_idx   = '0;
        dcol      = '0;
        wpos      = 0;
        col       = 0;
        pad_pend  = 1'b0;
        img_over  = 1'b0;
    endfunction

    function automatic void set_reg(logic [1:0] idx, logic [12:0] val);
        case (idx)
            brd_pkg::CFG_FOUR_BIT: nib_mode = val[0];
            brd_pkg::CFG_WIDTH:    width_reg = val;
            brd_pkg::CFG_HEIGHT:   height_reg = val;
            default:               return;
        endcase
        restart_decode();
    endfunction

    function automatic void emit_group(int unsigned addr, int unsigned n);
        pix_grp_t g;
        g = '0;
        g.addr = addr[23:0];
        g.pa = (n > 0) ? acc_px[0] : 8'h00;
        g.pb = (n > 1) ? acc_px[1] : 8'h00;
        g.pc = (n > 2) ? acc_px[2] : 8'h00;
        g.pd = (n > 3) ? acc_px[3] : 8'h00;
        g.cnt = n[2:0];
        byte_groups.push_back(g);
    endfunction

    function automatic void put_px(logic [7:0] v);
        if (img_over || col >= used_width())
            return;
        if (acc_n == 0)
            acc_addr = wpos;
        acc_px[acc_n] = v;
        acc_n++;
        wpos++;
        col++;
        if (acc_n == 4)
        begin
            emit_group(acc_addr, 4);
            acc_n = 0;
        end
        if (wpos >= pixel_total())
            img_over = 1'b1;
    endfunction

    // works out the pixel groups one compressed byte gives
    function automatic void decode_byte(logic [7:0] b, logic last);
        int unsigned     w;
        int unsigned     c;
        int unsigned     nbytes;
        longint unsigned pos;
        byte_groups.delete();
        if (img_over)
            return;
        acc_n = 0;
        w = used_width();
        case (dec_phase)
            brd_pkg::PH_VALUE:
            begin
                for (int k = 0; k < int'(run_len) && !img_over && col < w; k++)
                begin
                    if (nib_mode)
                        put_px(k[0] ? {4'h0, b[3:0]} : {4'h0, b[7:4]});
                    else
                        put_px(b);
                end
                dec_phase = brd_pkg::PH_COUNT;
            end
            brd_pkg::PH_ESC:
            begin
                if (b == brd_pkg::ESC_EOL)
                begin
                    wpos += w - col;
                    col = 0;
                    if (wpos >= pixel_total())
                        img_over = 1'b1;
                    dec_phase = brd_pkg::PH_COUNT;
                end
                else if (b == brd_pkg::ESC_EOI)
                begin
                    img_over = 1'b1;
                    dec_phase = brd_pkg::PH_COUNT;
                end
                else if (b == brd_pkg::ESC_DELTA)
                    dec_phase = brd_pkg::PH_DX;
                else
                begin
                    nbytes = nib_mode ? ((int'(b) + 1) >> 1) : int'(b);
                    run_len = b;
                    run_idx = '0;
                    pad_pend = nbytes[0];
                    dec_phase = brd_pkg::PH_ABS;
                end
            end
            brd_pkg::PH_DX:
            begin
                dcol = b;
                dec_phase = brd_pkg::PH_DY;
            end
            brd_pkg::PH_DY:
            begin
                c = col + dcol;
                if (c > w)
                    c = w;
                pos = longint'(wpos) + (c - col) + longint'(b) * w;
                col = c;
                if (pos >= pixel_total())
                begin
                    pos = pixel_total();
                    img_over = 1'b1;
                end
                wpos = int'(pos);
                dec_phase = brd_pkg::PH_COUNT;
            end
            brd_pkg::PH_ABS:
            begin
                if (nib_mode)
                begin
                    put_px({4'h0, b[7:4]});
                    run_idx++;
                    if (run_idx < run_len)
                    begin
                        put_px({4'h0, b[3:0]});
                        run_idx++;
                    end
                end
                else
                begin
                    put_px(b);
                    run_idx++;
                end
                if (run_idx >= run_len)
                    dec_phase = pad_pend ? brd_pkg::PH_PAD : brd_pkg::PH_COUNT;
            end
            brd_pkg::PH_PAD:
            begin
                pad_pend = 1'b0;
                dec_phase = brd_pkg::PH_COUNT;
            end
            default:
            begin
                if (b != RUN_ESCAPE)
                begin
                    run_len = b;
                    dec_phase = brd_pkg::PH_VALUE;
                end
                else
                    dec_phase = brd_pkg::PH_ESC;
            end
        endcase
        if (acc_n != 0)
            emit_group(acc_addr, acc_n);
        if (last)
            img_over = 1'b1;
        // a finishing byte with no pixels still reports where decoding stopped
        if (img_over && byte_groups.size() == 0)
            emit_group(wpos, 0);
        if (byte_groups.size() != 0)
        begin
            byte_groups[$].run_last = 1'b1;
            byte_groups[$].done = img_over;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic plan_row_t cfg_row(logic [1:0] idx, logic [12:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    function automatic plan_row_t byte_row(logic [7:0] b, logic last);
        plan_row_t r;
        r = '0;
        r.kind = ROW_BYTE;
        r.value = {5'd0, b};
        r.last = last;
        return r;
    endfunction

    // byte that ends the image with one group whose content is plain to see
    function automatic plan_row_t known_row(logic [7:0] b, logic last, logic [23:0] addr,
                                            logic [7:0] pa, logic [2:0] cnt);
        plan_row_t r;
        r = byte_row(b, last);
        r.typed = 1'b1;
        r.want.addr = addr;
        r.want.pa = pa;
        r.want.cnt = cnt;
        r.want.run_last = 1'b1;
        r.want.done = 1'b1;
        return r;
    endfunction

    function automatic logic [12:0] pick_dim(bit rows);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 13'd4096;
        else if (r < 15)
            return 13'd0;
        else if (r < 20)
            return 13'($urandom_range(8191, 4097));
        else if (r < 30)
            return 13'd1;
        else if (rows)
            return 13'($urandom_range(6, 1));
        return 13'($urandom_range(40, 1));
    endfunction

    task automatic drive_byte(input logic [7:0] b, input logic last, input logic typed,
                              input pix_grp_t want, output bit taken);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        taken = !img_over;
        decode_byte(b, last);
        if (typed)
            groups_due.push_back(want);
        else
            foreach (byte_groups[i])
                groups_due.push_back(byte_groups[i]);
    endtask

    // register writes only once every group is out and the byte path has settled
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        s_valid <= 1'b0;
        while (groups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        set_reg(idx, val);
    endtask

    task automatic send_sequence(inout int n_taken);
        logic [7:0] seq [$];
        int         r;
        int         len;
        int         nb;
        bit         taken;
        r = $urandom_range(99);
        if (r < 40)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(255, 1) : $urandom_range(16, 1);
            seq = '{8'(len), 8'($urandom)};
        end
        else if (r < 50)
            seq = '{RUN_ESCAPE, brd_pkg::ESC_EOL};
        else if (r < 55)
            seq = '{RUN_ESCAPE, brd_pkg::ESC_EOI};
        else if (r < 67)
        begin
            seq = '{RUN_ESCAPE, brd_pkg::ESC_DELTA, 8'($urandom)};
            seq.push_back(($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(2)));
        end
        else if (r < 90)
        begin
            len = ($urandom_range(24) == 0) ? $urandom_range(255, 3) : $urandom_range(24, 3);
            nb = nib_mode ? (len + 1) / 2 : len;
            seq = '{RUN_ESCAPE, 8'(len)};
            repeat (nb) seq.push_back(8'($urandom));
            if (nb % 2 != 0)
                seq.push_back(8'($urandom));
        end
        else
            seq = '{8'($urandom)};
        foreach (seq[i])
        begin
            drive_byte(seq[i], $urandom_range(99) < 3, 1'b0, '0, taken);
            n_taken += taken;
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_wanted && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_ready <= 1'b0;
        end
        else
            m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : group_check
        pix_grp_t got;
        pix_grp_t want;
        if (rst_n && m_axis_tvalid && m_ready)
        begin
            got.addr     = m_axis_tdata[23:0];
            got.pa       = m_axis_tdata[31:24];
            got.pb       = m_axis_tdata[39:32];
            got.pc       = m_axis_tdata[47:40];
            got.pd       = m_axis_tdata[55:48];
            got.cnt      = m_axis_tdata[58:56];
            got.run_last = m_axis_tlast;
            got.done     = m_axis_tuser;
            if (groups_due.size() == 0)
            begin
                $error("pixel group at address %0d with none due", got.addr);
                mismatches++;
            end
            else
            begin
                want = groups_due.pop_front();
                check_field("pixel_address", want.addr, got.addr);
                check_field("pixel_a", want.pa, got.pa);
                check_field("pixel_b", want.pb, got.pb);
                check_field("pixel_c", want.pc, got.pc);
                check_field("pixel_d", want.pd, got.pd);
                check_field("pixel_count", want.cnt, got.cnt);
                check_field("run_last", want.run_last, got.run_last);
                check_field("image_done", want.done, got.done);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        bit       taken;
        int       n_taken;
        pix_grp_t kick;

        nib_mode   = 1'b0;
        width_reg  = 13'd1;
        height_reg = 13'd1;
        restart_decode();

        // reset settings: one pixel fills the image
        plan.push_back(byte_row(8'h01, 1'b0));
        plan.push_back(known_row(8'hFF, 1'b0, 24'd0, 8'hFF, 3'd1));
        // widest row; height above the limit is clamped
        plan.push_back(cfg_row(brd_pkg::CFG_WIDTH, 13'd4096));
        plan.push_back(cfg_row(brd_pkg::CFG_HEIGHT, 13'd8191));
        plan.push_back(byte_row(RUN_ESCAPE, 1'b0));
        plan.push_back(known_row(brd_pkg::ESC_EOI, 1'b0, 24'd0, 8'h00, 3'd0));
        // longest run, widest delta, unmapped write, odd absolute run with pad
        plan.push_back(cfg_row(brd_pkg::CFG_HEIGHT, 13'd4096));
        plan.push_back(byte_row(8'hFF, 1'b0));
        plan.push_back(byte_row(8'h5A, 1'b0));
        plan.push_back(byte_row(RUN_ESCAPE, 1'b0));
        plan.push_back(byte_row(brd_pkg::ESC_DELTA, 1'b0));
        plan.push_back(byte_row(8'hFF, 1'b0));
        plan.push_back(byte_row(8'hFF, 1'b0));
        plan.push_back(cfg_row(CFG_SPARE, 13'h1FFF));
        plan.push_back(byte_row(RUN_ESCAPE, 1'b0));
        plan.push_back(byte_row(8'h03, 1'b0));
        plan.push_back(byte_row(8'h80, 1'b0));
        plan.push_back(byte_row(8'h01, 1'b0));
        plan.push_back(byte_row(8'h7F, 1'b0));
        plan.push_back(byte_row(8'h00, 1'b0));
        // nibble mode: clipped run, end of line, absolute run hitting the total
        plan.push_back(cfg_row(brd_pkg::CFG_FOUR_BIT, 13'd1));
        plan.push_back(cfg_row(brd_pkg::CFG_WIDTH, 13'd5));
        plan.push_back(cfg_row(brd_pkg::CFG_HEIGHT, 13'd2));
        plan.push_back(byte_row(8'h07, 1'b0));
        plan.push_back(byte_row(8'h12, 1'b0));
        plan.push_back(byte_row(RUN_ESCAPE, 1'b0));
        plan.push_back(byte_row(brd_pkg::ESC_EOL, 1'b0));
        plan.push_back(byte_row(RUN_ESCAPE, 1'b0));
        plan.push_back(byte_row(8'h05, 1'b0));
        plan.push_back(byte_row(8'h34, 1'b0));
        plan.push_back(byte_row(8'h56, 1'b0));
        plan.push_back(byte_row(8'h70, 1'b0));
        plan.push_back(byte_row(8'h00, 1'b0));     // image already full, dropped
        // zero width reads as one; stream cut off inside a delta
        plan.push_back(cfg_row(brd_pkg::CFG_WIDTH, 13'd0));
        plan.push_back(byte_row(RUN_ESCAPE, 1'b0));
        plan.push_back(byte_row(brd_pkg::ESC_DELTA, 1'b0));
        plan.push_back(known_row(8'h03, 1'b1, 24'd0, 8'h00, 3'd0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].value);
            else
                drive_byte(plan[i].value[7:0], plan[i].last, plan[i].typed, plan[i].want,
                           taken);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
                1:       begin send_idle_pct = 74; stall_pct <= 0;  end
                2:       begin send_idle_pct = 0;  stall_pct <= 74; end
                default: begin send_idle_pct = 22; stall_pct <= 22; end
            endcase
            case (p)
                0:
                begin
                    write_reg(brd_pkg::CFG_FOUR_BIT, 13'd0);
                    write_reg(brd_pkg::CFG_WIDTH, 13'd4096);
                    write_reg(brd_pkg::CFG_HEIGHT, 13'd4096);
                end
                1:
                begin
                    write_reg(brd_pkg::CFG_FOUR_BIT, 13'h1FFF);
                    write_reg(brd_pkg::CFG_WIDTH, 13'd1);
                    write_reg(brd_pkg::CFG_HEIGHT, 13'd4096);
                end
                2:
                begin
                    write_reg(brd_pkg::CFG_FOUR_BIT, 13'd1);
                    write_reg(brd_pkg::CFG_WIDTH, 13'd4096);
                    write_reg(brd_pkg::CFG_HEIGHT, 13'd1);
                end
                default:
                begin
                    write_reg(brd_pkg::CFG_FOUR_BIT, 13'($urandom));
                    write_reg(brd_pkg::CFG_WIDTH, pick_dim(1'b0));
                    write_reg(brd_pkg::CFG_HEIGHT, pick_dim(1'b1));
                end
            endcase
            n_taken = 0;
            if (p == 0)
            begin
                // output held off while a long run backs the input up
                hold_wanted <= 1'b1;
                kick = '0;
                drive_byte(8'd40, 1'b0, 1'b0, kick, taken);
                n_taken += taken;
                drive_byte(8'($urandom), 1'b0, 1'b0, kick, taken);
                n_taken += taken;
            end
            while (n_taken < PHASE_BYTES)
            begin
                if (img_over)
                begin
                    case ($urandom_range(2))
                        0:       write_reg(brd_pkg::CFG_FOUR_BIT, 13'($urandom));
                        1:       write_reg(brd_pkg::CFG_WIDTH, pick_dim(1'b0));
                        default: write_reg(brd_pkg::CFG_HEIGHT, pick_dim(1'b1));
                    endcase
                end
                send_sequence(n_taken);
            end
        end

        s_valid <= 1'b0;
        while (groups_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && groups_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
rtl/brd_pkg.sv
rtl/brd_ctrl.sv
rtl/brd_datapath.sv
rtl/bitmap_rle_decoder_core.sv
tb/bitmap_rle_decoder_core_test.sv
